FILE: src/rcd_pkg.sv
// Package for the reversible byte deque: function and status codes,
// the request and response word types, and default sizing.
// No dependencies.
package rcd_pkg;

  localparam int unsigned CapacityDef = 1024;
  localparam int unsigned FillW       = 11;

  // function codes
  localparam logic [1:0] FuncPush   = 2'd0;
  localparam logic [1:0] FuncToggle = 2'd1;
  localparam logic [1:0] FuncPop    = 2'd2;

  // status codes
  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic       side;
    logic [7:0] ch;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       data;
    logic [FillW-1:0] fill;
  } rsp_t;

endpackage

FILE: src/rcd_ram.sv
// Single-port byte store of the deque ring, with a registered read.
// Depends on nothing but its parameters.
module rcd_ram #(
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rcd_ctrl.sv
// Deque control: head/tail pointers, byte count, reversal flag, store access
// and the registered response. Uses rcd_pkg.
module rcd_ctrl
  import rcd_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef,
  localparam int unsigned PtrW = $clog2(Capacity),
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  req_t            req_i,
  output logic            mem_we_o,
  output logic            mem_re_o,
  output logic [PtrW-1:0] mem_addr_o,
  output logic [7:0]      mem_wdata_o,
  input  logic [7:0]      mem_rdata_i,
  output logic            valid_o,
  output rsp_t            rsp_o
);

  localparam logic [PtrW-1:0] PtrLast = PtrW'(Capacity - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Capacity);

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic            rev_q, rev_d;
  logic            valid_q, pop_ok_q, pop_ok_d;
  logic [1:0]      status_q, status_d;

  logic [PtrW-1:0] head_prev, head_next, tail_prev, tail_next;
  logic            full, empty;

  assign head_prev = (head_q == '0) ? PtrLast : head_q - PtrW'(1);
  assign head_next = (head_q == PtrLast) ? '0 : head_q + PtrW'(1);
  assign tail_prev = (tail_q == '0) ? PtrLast : tail_q - PtrW'(1);
  assign tail_next = (tail_q == PtrLast) ? '0 : tail_q + PtrW'(1);
  assign full  = (count_q == CntFull);
  assign empty = (count_q == '0);

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    rev_d       = rev_q;
    status_d    = StatOk;
    pop_ok_d    = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = head_q;
    mem_wdata_o = req_i.ch;
    if (accept_i) begin
      unique case (req_i.func)
        FuncPush: begin
          if (full) begin
            status_d = StatFull;
          end else begin
            mem_we_o = 1'b1;
            count_d  = count_q + CntW'(1);
            if ((req_i.side ^ rev_q) == 1'b0) begin
              // physical front
              head_d     = head_prev;
              mem_addr_o = head_prev;
            end else begin
              mem_addr_o = tail_q;
              tail_d     = tail_next;
            end
          end
        end
        FuncToggle: begin
          rev_d = ~rev_q;
        end
        FuncPop: begin
          if (empty) begin
            status_d = StatEmpty;
          end else begin
            mem_re_o = 1'b1;
            pop_ok_d = 1'b1;
            count_d  = count_q - CntW'(1);
            if (!rev_q) begin
              mem_addr_o = head_q;
              head_d     = head_next;
            end else begin
              mem_addr_o = tail_prev;
              tail_d     = tail_prev;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      rev_q    <= 1'b0;
      valid_q  <= 1'b0;
      pop_ok_q <= 1'b0;
      status_q <= StatOk;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      rev_q    <= rev_d;
      valid_q  <= accept_i;
      pop_ok_q <= pop_ok_d;
      status_q <= status_d;
    end
  end

  // popped byte comes straight from the store's read register
  assign valid_o       = valid_q;
  assign rsp_o.status  = status_q;
  assign rsp_o.data    = pop_ok_q ? mem_rdata_i : 8'h00;
  assign rsp_o.fill    = FillW'(count_q);

endmodule

FILE: src/reversible_char_deque.sv
// Top level of the reversible byte deque: control plus ring store.
// Uses rcd_pkg, rcd_ctrl and rcd_ram.
//
// Usage:
//   Drive req_i and raise start; the word is taken at any clock edge with
//   start high and busy low. busy stays low: one word can be taken every
//   cycle, so the sustained rate is one word per cycle.
//   Each word gives exactly one response on rsp_o, shown with valid_o high
//   in the cycle after the accepting edge.
//   A push writes its byte into the single-port store at the accepting edge;
//   a pop reads it at that edge, and the store's read register supplies the
//   byte during the response cycle. One store access per word sets the rate.
//   Pointers, count and reversal flag live in registers.
//   The receiver cannot stall: a response must be taken in its cycle.
//   Reset (rst_ni low, asynchronous) empties the deque and clears the
//   reversal flag; the store contents are not cleared and need no sweep.
module reversible_char_deque
  import rcd_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned PtrW = $clog2(CAPACITY);

  logic            accept;
  logic            mem_we, mem_re;
  logic [PtrW-1:0] mem_addr;
  logic [7:0]      mem_wdata, mem_rdata;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  rcd_ctrl #(
    .Capacity(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .valid_o     (valid_o),
    .rsp_o       (rsp_o)
  );

  rcd_ram #(
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

`ifndef ASSERT_OFF
  a_one_rsp_per_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> valid_o)
    else $error("accepted word produced no response");

  a_no_spurious_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !valid_o)
    else $error("response without accepted word");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == StatEmpty) |-> (rsp_o.fill == '0))
    else $error("empty status with nonzero fill");

  a_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status != StatOk) |-> (rsp_o.data == 8'h00))
    else $error("data on a refused word");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for reversible_char_deque: directed table, then random
// near-empty, fill-to-full and mixed phases, checked against typed rows or a bench model.
// Depends on rcd_pkg and the reversible_char_deque RTL.
module testbench;
  import rcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity = CapacityDef;
  localparam int unsigned PtrW     = $clog2(Capacity);
  // unused function code, must act as a no-op
  localparam logic [1:0]  FuncNone = 2'd3;
  localparam int          DirN     = 22;

  typedef struct packed {
    logic [1:0]       func;
    logic             side;
    logic [7:0]       ch;
    logic             typed;
    logic [1:0]       status;
    logic [7:0]       data;
    logic [FillW-1:0] fill;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic valid_o;
  rsp_t rsp_o;

  // deque model state
  logic [7:0]       dq_mem [Capacity];
  logic [PtrW-1:0]  dq_head  = '0;
  logic [PtrW-1:0]  dq_tail  = '0;
  logic [FillW-1:0] dq_count = '0;
  logic             dq_rev   = 1'b0;

  rsp_t rsp_q [$];
  int   err_cnt = 0;
  int   gap_pct = 0;

  // rows with typed results carry expected values written out by hand; others use the model
  dir_row_t dir_tab [DirN] = '{
    '{FuncPop,    1'b0, 8'h00, 1'b1, StatEmpty, 8'h00, 11'd0},
    '{FuncToggle, 1'b0, 8'h00, 1'b1, StatOk,    8'h00, 11'd0},
    '{FuncNone,   1'b1, 8'hFF, 1'b1, StatOk,    8'h00, 11'd0},
    '{FuncPop,    1'b1, 8'hFF, 1'b1, StatEmpty, 8'h00, 11'd0},
    '{FuncToggle, 1'b1, 8'hFF, 1'b1, StatOk,    8'h00, 11'd0},
    '{FuncPush,   1'b0, 8'h00, 1'b1, StatOk,    8'h00, 11'd1},
    '{FuncPush,   1'b1, 8'hFF, 1'b1, StatOk,    8'h00, 11'd2},
    '{FuncPush,   1'b0, 8'h80, 1'b1, StatOk,    8'h00, 11'd3},
    '{FuncPush,   1'b1, 8'h01, 1'b1, StatOk,    8'h00, 11'd4},
    '{FuncPop,    1'b0, 8'h00, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncToggle, 1'b0, 8'h00, 1'b1, StatOk,    8'h00, 11'd3},
    '{FuncPop,    1'b1, 8'h5A, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncPush,   1'b0, 8'h7F, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncPush,   1'b1, 8'hAA, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncNone,   1'b0, 8'h00, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncPop,    1'b0, 8'h00, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncToggle, 1'b0, 8'h00, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncPop,    1'b0, 8'h00, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncPop,    1'b0, 8'h00, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncPop,    1'b0, 8'h00, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncPop,    1'b0, 8'h00, 1'b0, StatOk,    8'h00, 11'd0},
    '{FuncPop,    1'b0, 8'h00, 1'b1, StatEmpty, 8'h00, 11'd0}
  };

  reversible_char_deque #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // Applies one word to the deque model and returns its response.
  // Pointer arithmetic wraps naturally since Capacity is a power of two.
  function automatic rsp_t deque_apply(req_t w);
    rsp_t r;
    r = '0;
    case (w.func)
      FuncPush: begin
        if (dq_count >= Capacity) begin
          r.status = StatFull;
        end else if ((w.side ^ dq_rev) == 1'b0) begin
          dq_head = dq_head - 1'b1;
          dq_mem[dq_head] = w.ch;
          dq_count = dq_count + 1'b1;
        end else begin
          dq_mem[dq_tail] = w.ch;
          dq_tail = dq_tail + 1'b1;
          dq_count = dq_count + 1'b1;
        end
      end
      FuncToggle: dq_rev = ~dq_rev;
      FuncPop: begin
        if (dq_count == 0) begin
          r.status = StatEmpty;
        end else if (!dq_rev) begin
          r.data = dq_mem[dq_head];
          dq_head = dq_head + 1'b1;
          dq_count = dq_count - 1'b1;
        end else begin
          dq_tail = dq_tail - 1'b1;
          r.data = dq_mem[dq_tail];
          dq_count = dq_count - 1'b1;
        end
      end
      default: ;
    endcase
    r.fill = dq_count;
    return r;
  endfunction

  function automatic req_t rand_word(int push_pct, int pop_pct);
    req_t w;
    int   roll;
    roll   = $urandom_range(99);
    w.side = 1'($urandom_range(1));
    w.ch   = 8'($urandom_range(255));
    if (roll < push_pct) begin
      w.func = FuncPush;
    end else if (roll < push_pct + pop_pct) begin
      w.func = FuncPop;
    end else begin
      w.func = ($urandom_range(3) == 0) ? FuncNone : FuncToggle;
    end
    return w;
  endfunction

  // Called right after a rising edge; returns right after the accepting edge, or after a random gap.
  task automatic send_word(req_t w, logic typed, rsp_t typed_rsp);
    rsp_t pred;
    start <= 1'b1;
    req_i <= w;
    @(negedge clk_i);
    while (busy !== 1'b0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
    pred = deque_apply(w);
    rsp_q.push_back(typed ? typed_rsp : pred);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic check_field(string what, logic [FillW-1:0] exp_v, logic [FillW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Response is on the ports for the cycle after acceptance; sample mid-cycle.
  always @(negedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && valid_o !== 1'b0) begin
      if (valid_o !== 1'b1) begin
        $display("%0t: valid_o unknown", $time);
        err_cnt++;
      end else if (rsp_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %p", $time, rsp_o);
        err_cnt++;
      end else begin
        exp_r = rsp_q.pop_front();
        check_field("status", FillW'(exp_r.status), FillW'(rsp_o.status));
        check_field("data", FillW'(exp_r.data), FillW'(rsp_o.data));
        check_field("fill", exp_r.fill, rsp_o.fill);
      end
    end
  end

  initial begin : stim
    req_t     w;
    rsp_t     tr;
    int       hits;
    int       drain_wait;
    dir_row_t row;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 25;
    for (int i = 0; i < DirN; i++) begin
      row = dir_tab[i];
      w   = '{func: row.func, side: row.side, ch: row.ch};
      tr  = '{status: row.status, data: row.data, fill: row.fill};
      send_word(w, row.typed, tr);
    end

    // short mix near empty
    for (int i = 0; i < 60; i++) begin
      if (i % 64 == 0) gap_pct = ($urandom_range(2) == 0) ? 0 : 25;
      send_word(rand_word(45, 45), 1'b0, '0);
    end

    // fill to capacity and keep pushing into the full store
    hits = 0;
    for (int i = 0; hits < 16; i++) begin
      if (i % 64 == 0) gap_pct = ($urandom_range(2) == 0) ? 0 : 20;
      w = rand_word(96, 2);
      if (w.func == FuncPush && dq_count == Capacity) hits++;
      send_word(w, 1'b0, '0);
    end

    // back to back to the end
    gap_pct = 0;
    for (int i = 0; i < 100; i++) begin
      send_word(rand_word(50, 40), 1'b0, '0);
    end
    start <= 1'b0;

    drain_wait = 0;
    while (rsp_q.size() != 0 && drain_wait < 100) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (4) @(posedge clk_i);
    if (rsp_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, rsp_q.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("%0t: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
